// ===== sv/lsq_pkg.sv =====
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared types and constants for the LIFO stack with search queries.
// ----------------------------------------------------------------------------
package lsq_pkg;

   // default sizing, handed down as top-level parameters
   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_WORD_WIDTH  = 32;

   // fixed field widths on the stream ports
   localparam int DATA_W = 32;   // value / popped_value
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_FIND  = 2'd2,
      CMD_ABOVE = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_POP_EMPTY = 2'd1,
      STAT_PUSH_FULL = 2'd2
   } stat_type;

   // sequencer -> compare unit
   typedef struct packed {
      logic valid;      // entry data on the RAM read port is part of a scan
      logic find_mode;  // 1: equality against key, 0: above-mean test
   } scan_req_type;

   // compare unit -> sequencer
   typedef struct packed {
      logic valid;
      logic hit;
   } scan_rsp_type;

endpackage

// ===== sv/lsq_ram.sv =====
// ----------------------------------------------------------------------------
// lsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lsq_scan.sv =====
// ----------------------------------------------------------------------------
// lsq_scan
// Shared compare unit used by find and count-above-mean scans.
// Stage 1 registers key match and entry*count; sum compare is combinational.
// ----------------------------------------------------------------------------
module lsq_scan #(
   parameter int WORD_WIDTH = lsq_pkg::DEF_WORD_WIDTH,
   parameter int CNT_W      = 7,
   parameter int SUM_W      = 38
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lsq_pkg::scan_req_type       scan_req,
   input  logic signed [WORD_WIDTH-1:0] entry,
   input  logic signed [WORD_WIDTH-1:0] key,
   input  logic [CNT_W-1:0]            count,
   input  logic signed [SUM_W-1:0]     sum,
   output lsq_pkg::scan_rsp_type       scan_rsp
);

   localparam int PROD_W = WORD_WIDTH + CNT_W + 1;

   logic                     valid_ff;
   logic                     mode_ff;
   logic                     eq_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [CNT_W:0]    count_s;

   assign count_s = $signed({1'b0, count});
   assign prod_in = PROD_W'(entry) * PROD_W'(count_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= scan_req.valid;
      end
      mode_ff <= scan_req.find_mode;
      eq_ff   <= (entry == key);
      prod_ff <= prod_in;
   end

   always_comb begin
      scan_rsp.valid = valid_ff;
      scan_rsp.hit   = mode_ff ? eq_ff : (prod_ff > PROD_W'(sum));
   end

endmodule

// ===== sv/lifo_stack_with_queries.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_queries
// Push and failing pop go from accept to S_FIN; pop passes S_POP (RAM read) first.
// Find/count-above-mean walk the stack one entry per cycle through one shared
// compare/multiply unit, via S_SCAN and S_DRAIN (empty stack: straight to S_FIN).
// One transaction at a time; req_tready returns with rsp_tvalid, once S_FIN
// has loaded the result into the output register.
// Synchronous active-high reset empties the stack and zeroes the running sum.
// ----------------------------------------------------------------------------
module lifo_stack_with_queries #(
   parameter int STACK_DEPTH = lsq_pkg::DEF_STACK_DEPTH,
   parameter int WORD_WIDTH  = lsq_pkg::DEF_WORD_WIDTH,
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1),
   localparam int RSP_BITS    = lsq_pkg::DATA_W + 3 * CNT_W,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [lsq_pkg::DATA_W-1:0]  req_tdata,   // [31:0] value
   input  logic [lsq_pkg::CMD_W-1:0]   req_tuser,   // [1:0] command
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // popped_value, found_position,
                                                    // above_mean_count, occupancy,
                                                    // zero pad (low to high)
   output logic [lsq_pkg::STAT_W-1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int SUM_W = WORD_WIDTH + $clog2(STACK_DEPTH);
   localparam int PAD_W = RSP_TDATA_W - RSP_BITS;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_POP   = 5'b00010,   // RAM read data for pop is valid
      S_SCAN  = 5'b00100,   // issuing one RAM read per cycle
      S_DRAIN = 5'b01000,   // waiting for the compare pipeline to empty
      S_FIN   = 5'b10000    // load result into output register
   } state_type;

   state_type state_ff, state_in;

   // stack state
   logic [CNT_W-1:0]             top_ff, top_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;

   // command in progress
   lsq_pkg::cmd_type             cmd_ff, cmd_in;
   logic signed [WORD_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;    // reads issued
   logic [CNT_W-1:0]             ret_ff, ret_in;    // compare results seen
   logic                         scan_rd_ff;        // RAM data belongs to a scan
   logic [CNT_W-1:0]             found_ff, found_in;
   logic [CNT_W-1:0]             above_ff, above_in;
   logic signed [WORD_WIDTH-1:0] popv_ff, popv_in;
   lsq_pkg::stat_type            stat_ff, stat_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lsq_pkg::DATA_W-1:0]   rsp_popped_ff;
   logic [CNT_W-1:0]             rsp_found_ff;
   logic [CNT_W-1:0]             rsp_above_ff;
   logic [CNT_W-1:0]             rsp_occ_ff;
   lsq_pkg::stat_type            rsp_stat_ff;
   logic                         rsp_load;

   // request decode
   logic                         req_acc;
   lsq_pkg::cmd_type             req_cmd;
   logic signed [WORD_WIDTH-1:0] req_val;
   logic                         is_empty;
   logic                         is_full;

   // RAM and compare unit hookup
   logic                         ram_we;
   logic                         ram_re;
   logic [CNT_W-1:0]             rd_ptr;
   logic signed [WORD_WIDTH-1:0] ram_rdata;
   lsq_pkg::scan_req_type        scan_req;
   lsq_pkg::scan_rsp_type        scan_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_cmd    = lsq_pkg::cmd_type'(req_tuser);
   assign req_val    = req_tdata[WORD_WIDTH-1:0];
   assign is_empty   = (top_ff == '0);
   assign is_full    = (top_ff == CNT_W'(STACK_DEPTH));

   // output register is free when empty or being drained this cycle
   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);

   // read pointer: top entry for pop, walking down from the top for a scan
   assign rd_ptr = top_ff - CNT_W'(1) - ((state_ff == S_SCAN) ? idx_ff : '0);
   assign ram_we = req_acc && (req_cmd == lsq_pkg::CMD_PUSH) && !is_full;
   assign ram_re = (req_acc && (req_cmd == lsq_pkg::CMD_POP) && !is_empty) ||
                   (state_ff == S_SCAN);

   lsq_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (top_ff[AW-1:0]),
      .wr_data (req_val),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      scan_req.valid     = scan_rd_ff;
      scan_req.find_mode = (cmd_ff == lsq_pkg::CMD_FIND);
   end

   lsq_scan #(
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .entry    (ram_rdata),
      .key      (key_ff),
      .count    (top_ff),
      .sum      (sum_ff),
      .scan_rsp (scan_rsp)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      top_in   = top_ff;
      sum_in   = sum_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      ret_in   = ret_ff;
      found_in = found_ff;
      above_in = above_ff;
      popv_in  = popv_ff;
      stat_in  = stat_ff;

      // compare results arrive in read order: the n-th one is position n
      if (scan_rsp.valid) begin
         ret_in = ret_ff + CNT_W'(1);
         if (scan_rsp.hit) begin
            if (cmd_ff == lsq_pkg::CMD_FIND) begin
               if (found_ff == '0) begin
                  found_in = ret_ff + CNT_W'(1);
               end
            end else begin
               above_in = above_ff + CNT_W'(1);
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               cmd_in   = req_cmd;
               key_in   = req_val;
               idx_in   = '0;
               ret_in   = '0;
               found_in = '0;
               above_in = '0;
               popv_in  = '0;
               stat_in  = lsq_pkg::STAT_OK;
               state_in = S_FIN;
               unique case (req_cmd) inside
                  lsq_pkg::CMD_PUSH: begin
                     if (is_full) begin
                        stat_in = lsq_pkg::STAT_PUSH_FULL;
                     end else begin
                        top_in = top_ff + CNT_W'(1);
                        sum_in = sum_ff + SUM_W'(req_val);
                     end
                  end
                  lsq_pkg::CMD_POP: begin
                     if (is_empty) begin
                        stat_in = lsq_pkg::STAT_POP_EMPTY;
                     end else begin
                        top_in   = top_ff - CNT_W'(1);
                        state_in = S_POP;
                     end
                  end
                  lsq_pkg::CMD_FIND, lsq_pkg::CMD_ABOVE: begin
                     if (!is_empty) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_POP: begin
            popv_in  = ram_rdata;
            sum_in   = sum_ff - SUM_W'(ram_rdata);
            state_in = S_FIN;
         end
         S_SCAN: begin
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == top_ff - CNT_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!scan_rd_ff && !scan_rsp.valid) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         sum_ff       <= '0;
         scan_rd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         sum_ff       <= sum_in;
         scan_rd_ff   <= (state_ff == S_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      idx_ff   <= idx_in;
      ret_ff   <= ret_in;
      found_ff <= found_in;
      above_ff <= above_in;
      popv_ff  <= popv_in;
      stat_ff  <= stat_in;
      if (rsp_load) begin
         rsp_popped_ff <= lsq_pkg::DATA_W'(popv_ff);
         rsp_found_ff  <= found_ff;
         rsp_above_ff  <= above_ff;
         rsp_occ_ff    <= top_ff;
         rsp_stat_ff   <= stat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_occ_ff, rsp_above_ff, rsp_found_ff, rsp_popped_ff};
   assign rsp_tuser  = rsp_stat_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack occupancy beyond depth");

   // pop lowers the count at accept and the sum in S_POP, the state that follows
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      ((top_ff == '0) && (state_ff != S_POP)) |-> (sum_ff == '0))
      else $error("running sum nonzero on empty stack");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_cmd == lsq_pkg::CMD_PUSH) && !is_full)
         |=> (top_ff == $past(top_ff) + CNT_W'(1)))
      else $error("accepted push did not grow the stack");

   a_found_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_found_ff <= rsp_occ_ff))
      else $error("found position beyond occupancy");

   a_above_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_occ_ff != '0)) |-> (rsp_above_ff < rsp_occ_ff))
      else $error("every entry counted above the mean");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lifo_stack_with_queries. A directed table covers the
// empty and full corners, word extremes and all four commands. Random
// push/pop/find/count traffic follows, swept between fill-heavy and
// drain-heavy phases. Checks use a stack model, or a typed row's answer.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH    = 64;
   localparam int RSP_W    = 56;     // 32 + 3 * 7 bits, padded to bytes
   localparam int SCAN_LAT = DEPTH + 16;  // drain wait after the last response

   // one response, field by field
   typedef struct packed {
      logic [31:0]       popped;
      logic [6:0]        found;
      logic [6:0]        above;
      logic [6:0]        occ;
      lsq_pkg::stat_type status;
   } rsp_fields_type;

   // directed stimulus row; typed == 1 means rsp holds the hand-written answer
   typedef struct packed {
      lsq_pkg::cmd_type cmd;
      logic [31:0]      value;
      logic [6:0]       reps;
      logic             typed;
      rsp_fields_type   rsp;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;    // [31:0] value
   logic [1:0]        req_tuser;    // [1:0] command
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;    // popped_value, found_position,
                                    // above_mean_count, occupancy, pad
   logic [1:0]        rsp_tuser;    // [1:0] status

   // stack model
   logic signed [31:0] stack_model [0:DEPTH-1];
   int                 model_depth;
   longint             model_sum;

   rsp_fields_type     pending_rsp [$];
   dir_row_type        stim_rows [$];
   int                 err_count = 0;
   bit                 quiet = 1'b0;   // suppresses idle cycles on both sides

   lifo_stack_with_queries dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the stack model by one command and return what the block owes.
   function automatic rsp_fields_type predict_response(lsq_pkg::cmd_type cmd,
                                                       logic [31:0] value);
      rsp_fields_type r;
      r = '0;
      r.status = lsq_pkg::STAT_OK;
      case (cmd)
         lsq_pkg::CMD_PUSH: begin
            if (model_depth >= DEPTH) begin
               r.status = lsq_pkg::STAT_PUSH_FULL;
            end else begin
               stack_model[model_depth] = value;
               model_depth++;
               model_sum += longint'($signed(value));
            end
         end
         lsq_pkg::CMD_POP: begin
            if (model_depth == 0) begin
               r.status = lsq_pkg::STAT_POP_EMPTY;
            end else begin
               model_depth--;
               r.popped = stack_model[model_depth];
               model_sum -= longint'(stack_model[model_depth]);
            end
         end
         lsq_pkg::CMD_FIND: begin
            // first match counted from the top, 1-based
            for (int pos = 0; pos < model_depth; pos++) begin
               if (r.found == 0 && stack_model[model_depth - 1 - pos] == value)
                  r.found = 7'(pos + 1);
            end
         end
         default: begin
            // exact mean test: entry * count > sum, no division
            for (int i = 0; i < model_depth; i++) begin
               if (longint'(stack_model[i]) * longint'(model_depth) > model_sum)
                  r.above++;
            end
         end
      endcase
      r.occ = 7'(model_depth);
      return r;
   endfunction

   function automatic dir_row_type mk_row(lsq_pkg::cmd_type cmd, logic [31:0] value,
                                          int reps, bit typed, logic [31:0] popped,
                                          int found, int above, int occ,
                                          lsq_pkg::stat_type status);
      dir_row_type d;
      d.cmd        = cmd;
      d.value      = value;
      d.reps       = 7'(reps);
      d.typed      = typed;
      d.rsp.popped = popped;
      d.rsp.found  = 7'(found);
      d.rsp.above  = 7'(above);
      d.rsp.occ    = 7'(occ);
      d.rsp.status = status;
      return d;
   endfunction

   // random idle decision, true with a chance of about 22 percent
   function automatic bit take_gap();
      return !quiet && ($urandom_range(99) < 22);
   endfunction

   // Random word: often full-range, with extremes, small values for
   // duplicates and mean ties, and copies of held entries for find hits.
   function automatic logic [31:0] rand_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40)
         return $urandom;
      if (pick < 55) begin
         case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      if (pick < 80 || model_depth == 0)
         return 32'($signed($urandom_range(16)) - 8);
      return stack_model[$urandom_range(model_depth - 1)];
   endfunction

   // Drive one request transaction starting at a falling edge; the
   // expectation is recorded at the rising edge that accepts it.
   task automatic send_request(lsq_pkg::cmd_type cmd, logic [31:0] value, bit typed,
                               rsp_fields_type typed_rsp);
      rsp_fields_type predicted;
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 2'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_response(cmd, value);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // Response ready: random back-pressure, changed at the falling edge
   always @(negedge clock) begin
      rsp_tready <= !take_gap();
   end

   // Response checker: one transaction per rising edge with valid and ready
   always @(posedge clock) begin
      rsp_fields_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding: tdata %h tuser %0d",
                   rsp_tdata, rsp_tuser);
            err_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_tdata[31:0] !== exp_rsp.popped) begin
               $error("popped_value expected %0d got %0d",
                      $signed(exp_rsp.popped), $signed(rsp_tdata[31:0]));
               err_count++;
            end
            if (rsp_tdata[38:32] !== exp_rsp.found) begin
               $error("found_position expected %0d got %0d",
                      exp_rsp.found, rsp_tdata[38:32]);
               err_count++;
            end
            if (rsp_tdata[45:39] !== exp_rsp.above) begin
               $error("above_mean_count expected %0d got %0d",
                      exp_rsp.above, rsp_tdata[45:39]);
               err_count++;
            end
            if (rsp_tdata[52:46] !== exp_rsp.occ) begin
               $error("occupancy expected %0d got %0d",
                      exp_rsp.occ, rsp_tdata[52:46]);
               err_count++;
            end
            if (rsp_tuser !== exp_rsp.status) begin
               $error("status expected %0d got %0d", exp_rsp.status, rsp_tuser);
               err_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, random traffic, drain
   initial begin
      dir_row_type      r;
      rsp_fields_type   none;
      int               push_pct;
      int               pick;
      lsq_pkg::cmd_type cmd;
      logic [31:0]      value;

      none        = '0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      model_depth = 0;
      model_sum   = 0;

      // Directed table. Typed rows carry an answer readable at a glance.
      // empty stack: pop underflow, count and find on nothing
      stim_rows.push_back(mk_row(lsq_pkg::CMD_POP,   32'h0, 1, 1, 0, 0, 0, 0,
                                 lsq_pkg::STAT_POP_EMPTY));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_ABOVE, 32'h0, 1, 1, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_FIND,  32'h0, 1, 1, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      // word extremes
      stim_rows.push_back(mk_row(lsq_pkg::CMD_PUSH, 32'h7fff_ffff, 1, 1, 0, 0, 0, 1,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_PUSH, 32'h8000_0000, 1, 1, 0, 0, 0, 2,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_FIND, 32'h8000_0000, 1, 1, 0, 1, 0, 2,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_FIND, 32'h7fff_ffff, 1, 1, 0, 2, 0, 2,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_FIND, 32'h0,         1, 1, 0, 0, 0, 2,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_ABOVE, 32'h0, 1, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      // duplicates: find must report the topmost copy
      stim_rows.push_back(mk_row(lsq_pkg::CMD_PUSH, 32'hffff_ffff, 1, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_PUSH, 32'd5,         2, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_FIND, 32'd5,         1, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_ABOVE, 32'h0,        1, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_POP,  32'h0,         5, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_POP,  32'h0, 1, 1, 0, 0, 0, 0,
                                 lsq_pkg::STAT_POP_EMPTY));
      // full of max words: overflow, all equal means nothing above mean
      stim_rows.push_back(mk_row(lsq_pkg::CMD_PUSH, 32'h7fff_ffff, 64, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_PUSH, 32'h1, 1, 1, 0, 0, 0, 64,
                                 lsq_pkg::STAT_PUSH_FULL));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_ABOVE, 32'h0, 1, 1, 0, 0, 0, 64,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_FIND, 32'h7fff_ffff, 1, 1, 0, 1, 0, 64,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_POP,  32'h0, 64, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      // full of min words: most negative running sum, miss on a full walk
      stim_rows.push_back(mk_row(lsq_pkg::CMD_PUSH, 32'h8000_0000, 64, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_ABOVE, 32'h0, 1, 1, 0, 0, 0, 64,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_FIND, 32'h7fff_ffff, 1, 1, 0, 0, 0, 64,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_POP,  32'h0, 64, 0, 0, 0, 0, 0,
                                 lsq_pkg::STAT_OK));
      stim_rows.push_back(mk_row(lsq_pkg::CMD_POP,  32'h0, 1, 1, 0, 0, 0, 0,
                                 lsq_pkg::STAT_POP_EMPTY));

      // hold reset, then release it at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i]) begin
         r = stim_rows[i];
         for (int k = 0; k < r.reps; k++)
            send_request(r.cmd, r.value, r.typed, r.rsp);
      end

      // Random traffic in phases of 55 transactions, sweeping the push share
      // so the stack repeatedly fills to overflow and drains to underflow.
      for (int n = 0; n < 1368; n++) begin
         quiet = (n >= 500 && n < 850);   // back-to-back stretch, no idling
         case ((n / 55) % 6)
            0: push_pct = 90;
            1: push_pct = 60;
            2: push_pct = 10;
            3: push_pct = 75;
            4: push_pct = 40;
            default: push_pct = 5;
         endcase
         pick = $urandom_range(99);
         if (pick < push_pct) begin
            cmd = lsq_pkg::CMD_PUSH;
         end else begin
            pick = $urandom_range(9);
            cmd  = (pick < 5) ? lsq_pkg::CMD_POP :
                   (pick < 8) ? lsq_pkg::CMD_FIND : lsq_pkg::CMD_ABOVE;
         end
         // pop and count ignore the value; keep it random anyway
         value = (cmd == lsq_pkg::CMD_POP || cmd == lsq_pkg::CMD_ABOVE) ?
                 $urandom : rand_word();
         send_request(cmd, value, 1'b0, none);
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then allow a full scan's worth of cycles for strays
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SCAN_LAT) @(posedge clock);

      if (err_count == 0) begin
         $display("PASS lifo_stack_with_queries");
      end else begin
         $display("FAIL lifo_stack_with_queries");
      end
      $finish;
   end

   // watchdog: 10 ms, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("FAIL lifo_stack_with_queries");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/lsq_pkg.sv
sv/lsq_ram.sv
sv/lsq_scan.sv
sv/lifo_stack_with_queries.sv
sim/testbench.sv
